// ----- sv/weighted_moving_average_top_macros.svh -----
// Assertion macros for the weighted moving average block.
`ifndef WEIGHTED_MOVING_AVERAGE_TOP_MACROS_SVH
`define WEIGHTED_MOVING_AVERAGE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define WMA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define WMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WMA_ASSERT(label, clk, rst_n, prop, msg)
`define WMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- sv/wma_pkg.sv -----
// Shared types and constants of the weighted moving average block.
`default_nettype none
package wma_pkg;
  localparam int unsigned MaxTaps = 6;
  localparam int unsigned CntW = 3;
  localparam int unsigned IdxW = 3;
  localparam int unsigned CfgW = 16;
  localparam int unsigned AccW = 36;
  localparam int unsigned DenW = 20;

  localparam logic [IdxW-1:0] RegWindow = 3'd0;
  localparam logic [IdxW-1:0] RegWeightLast = 3'd6;

  // One request handed from the front end to the arithmetic back end.
  typedef struct packed {
    logic signed [MaxTaps-1:0][15:0] hist;
    logic [CntW-1:0] used;
  } job_t;
endpackage
`default_nettype wire

// ----- sv/wma_front.sv -----
// Front end: sample history, window bookkeeping and the job queue.
`default_nettype none
module wma_front import wma_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic [2:0] window_length_i,
  input  wire logic sample_valid_i,
  output logic sample_stall_o,
  input  wire logic signed [15:0] sample_i,
  output logic job_valid_o,
  input  wire logic job_take_i,
  output job_t job_o
);
  logic signed [MaxTaps-1:0][15:0] hist_q, hist_d;
  logic [CntW-1:0] held_q, held_d, win;
  job_t q_mem_q [2];
  logic [0:0] wr_q, rd_q;
  logic [1:0] cnt_q;
  logic push;

  always_comb begin
    win = window_length_i;
    if (win == '0) win = 3'd1;
    if (win > CntW'(MaxTaps)) win = CntW'(MaxTaps);
    held_d = (held_q + 3'd1 > win) ? win : held_q + 3'd1;
    hist_d = {hist_q[MaxTaps-2:0], sample_i};
  end

  assign sample_stall_o = (cnt_q == 2'd2);
  assign push = sample_valid_i && !sample_stall_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o = q_mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      held_q <= '0;
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        hist_q <= hist_d;
        held_q <= held_d;
        wr_q <= ~wr_q;
      end
      if (job_take_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, job_take_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wr_q] <= '{hist: hist_d, used: held_d};
  end
endmodule
`default_nettype wire

// ----- sv/wma_back.sv -----
// Back end: serial multiply-accumulate, restoring division and saturation.
`default_nettype none
module wma_back import wma_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic signed [MaxTaps-1:0][15:0] weight_i,
  input  wire logic job_valid_i,
  output logic job_take_o,
  input  wire job_t job_i,
  output logic result_valid_o,
  input  wire logic result_stall_i,
  output logic signed [15:0] average_o,
  output logic saturated_o,
  output logic zero_weight_sum_o,
  output logic [2:0] samples_used_o
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMac = 2'd1;
  localparam logic [1:0] StDiv = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0] st_q;
  job_t job_q;
  logic [2:0] tap_q;
  logic [5:0] bit_q;
  logic signed [AccW-1:0] wsum_q;
  logic signed [DenW-1:0] tsum_q;
  logic [AccW-1:0] quo_q;
  logic [DenW:0] rem_q;
  logic neg_q;
  logic signed [31:0] prod;
  logic [AccW-1:0] num_abs;
  logic [DenW-1:0] den_abs;
  logic [DenW:0] trial;
  logic [AccW-1:0] quo_next;
  logic signed [AccW:0] qs;
  logic signed [AccW-1:0] zsum;

  assign prod = $signed(job_q.hist[tap_q]) * $signed(weight_i[tap_q]);
  assign num_abs = wsum_q[AccW-1] ? AccW'(-wsum_q) : AccW'(wsum_q);
  assign den_abs = tsum_q[DenW-1] ? DenW'(-tsum_q) : DenW'(tsum_q);
  assign trial = {rem_q[DenW-1:0], quo_q[AccW-1]};
  assign quo_next = {quo_q[AccW-2:0], (trial >= {1'b0, den_abs})};
  assign qs = neg_q ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
  assign zsum = wsum_q >>> 8;
  assign job_take_o = (st_q == StIdle) && job_valid_i;
  assign result_valid_o = (st_q == StDone);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      unique case (st_q)
        StIdle: if (job_valid_i) st_q <= StMac;
        StMac: if (tap_q + 3'd1 >= job_q.used) st_q <= StDiv;
        StDiv: if (tsum_q == '0 || bit_q == 6'd0) st_q <= StDone;
        StDone: if (!result_stall_i) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: begin
        job_q <= job_i;
        tap_q <= '0;
        wsum_q <= '0;
        tsum_q <= '0;
        rem_q <= '0;
        bit_q <= 6'(AccW);
      end
      StMac: begin
        wsum_q <= wsum_q + AccW'(prod);
        tsum_q <= tsum_q + DenW'($signed(weight_i[tap_q]));
        tap_q <= tap_q + 3'd1;
        quo_q <= '0;
      end
      StDiv: begin
        if (bit_q == 6'(AccW)) begin
          // Load magnitudes; the quotient register shifts out the dividend.
          quo_q <= num_abs;
          neg_q <= wsum_q[AccW-1] ^ tsum_q[DenW-1];
          bit_q <= bit_q - 6'd1;
        end else begin
          if (bit_q == 6'd0) bit_q <= bit_q;
          else bit_q <= bit_q - 6'd1;
          if (trial >= {1'b0, den_abs}) begin
            rem_q <= trial - {1'b0, den_abs};
            quo_q <= {quo_q[AccW-2:0], 1'b1};
          end else begin
            rem_q <= trial;
            quo_q <= {quo_q[AccW-2:0], 1'b0};
          end
        end
        if (tsum_q == '0) begin
          zero_weight_sum_o <= 1'b1;
          saturated_o <= (zsum > 36'sd32767) || (zsum < -36'sd32768);
          average_o <= (zsum > 36'sd32767) ? 16'sh7fff :
                       (zsum < -36'sd32768) ? -16'sh8000 : zsum[15:0];
          samples_used_o <= job_q.used;
        end
      end
      StDone: ;
      default: ;
    endcase
    if (st_q == StDiv && tsum_q != '0 && bit_q == 6'd0) begin
      zero_weight_sum_o <= 1'b0;
      saturated_o <= (qs > 37'sd32767) || (qs < -37'sd32768);
      average_o <= (qs > 37'sd32767) ? 16'sh7fff :
                   (qs < -37'sd32768) ? -16'sh8000 : qs[15:0];
      samples_used_o <= job_q.used;
    end
  end
endmodule
`default_nettype wire

// ----- sv/weighted_moving_average_top.sv -----
// Top level of the weighted moving average block.
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+--------------------------------
//  sample   | sample_valid_i / sample_stall_o  | sample_i
//  result   | result_valid_o / result_stall_i  | average_o, saturated_o, ...
//  config   | cfg_we_i                         | cfg_index_i, cfg_data_i
//
// In the back end an item passes a load state, one multiply-accumulate step per
// used tap on the single 16x16 multiplier, a load and 36 steps of the restoring
// divider (skipped when the weight sum is zero), and a state holding the result.
// The front end queues up to two requests, so samples keep entering meanwhile.
// Reset restores window length 6, unity weights and an empty history.
// A stalled result holds the back end; the queue then fills and stalls samples.
`default_nettype none
`include "weighted_moving_average_top_macros.svh"
module weighted_moving_average_top import wma_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [IdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0] cfg_data_i,
  input  wire logic sample_valid_i,
  output logic sample_stall_o,
  input  wire logic signed [15:0] sample_i,
  output logic result_valid_o,
  input  wire logic result_stall_i,
  output logic signed [15:0] average_o,
  output logic saturated_o,
  output logic zero_weight_sum_o,
  output logic [2:0] samples_used_o
);
  logic [2:0] window_q;
  logic signed [MaxTaps-1:0][15:0] weight_q;
  logic job_valid, job_take;
  job_t job;

  // Configuration registers; indexes beyond the last weight are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= 3'd6;
      weight_q <= {MaxTaps{16'sd256}};
    end else if (cfg_we_i) begin
      if (cfg_index_i == RegWindow) window_q <= cfg_data_i[2:0];
      else if (cfg_index_i <= RegWeightLast)
        weight_q[cfg_index_i - 3'd1] <= cfg_data_i;
    end
  end

  wma_front u_front (
    .clk_i, .rst_ni,
    .window_length_i(window_q),
    .sample_valid_i, .sample_stall_o, .sample_i,
    .job_valid_o(job_valid), .job_take_i(job_take), .job_o(job)
  );

  wma_back u_back (
    .clk_i, .rst_ni,
    .weight_i(weight_q),
    .job_valid_i(job_valid), .job_take_o(job_take), .job_i(job),
    .result_valid_o, .result_stall_i,
    .average_o, .saturated_o, .zero_weight_sum_o, .samples_used_o
  );

  `WMA_ASSERT(a_used_range, clk_i, rst_ni, !result_valid_o || (samples_used_o != 3'd0 && samples_used_o <= 3'd6), "samples used out of range")
  `WMA_ASSERT(a_take_valid, clk_i, rst_ni, !job_take || job_valid, "job taken from empty queue")
  `WMA_ASSERT_NEXT(a_sat_hold, clk_i, rst_ni, result_valid_o && result_stall_i, $stable(average_o) && result_valid_o, "stalled result changed")
endmodule
`default_nettype wire

// ----- verif/weighted_moving_average_top_tb.sv -----
// Testbench of the weighted moving average block: directed table, random runs, self check.
`default_nettype none
module weighted_moving_average_top_tb import wma_pkg::*; ();

  // Handshakes on both channels use valid and stall. Inputs change on the
  // falling clock edge, and outputs are sampled on the rising edge. This keeps
  // the results free of event-order races within a time step.

  typedef struct packed {
    logic signed [15:0] average;
    logic               saturated;
    logic               zero_weight_sum;
    logic [2:0]         samples_used;
  } wma_result_t;

  // One row of the directed table. When has_expect is set, the typed-in
  // result is checked against the predictor's result as well.
  typedef struct {
    logic signed [15:0] sample;
    bit                 has_expect;
    wma_result_t        want;
  } wma_row_t;

  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [IdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic sample_valid_i = 1'b0;
  logic sample_stall_o;
  logic signed [15:0] sample_i = '0;
  logic result_valid_o;
  logic result_stall_i = 1'b0;
  logic signed [15:0] average_o;
  logic saturated_o;
  logic zero_weight_sum_o;
  logic [2:0] samples_used_o;

  weighted_moving_average_top dut (.*);

  always #6 clk_i = ~clk_i;

  // Predictor state: its own copy of the registers and of the sample history.
  logic [2:0] window_reg;
  logic signed [15:0] weight_reg [MaxTaps];
  logic signed [15:0] history [MaxTaps];
  int unsigned held_count;

  wma_result_t pending_results[$];
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned zero_sum_seen = 0;
  int unsigned sat_seen = 0;
  int unsigned cycles = 0;

  // When set, the receiver raises its stall for a long stretch.
  bit hold_off = 1'b0;

  task automatic reset_model();
    window_reg = 3'd6;
    for (int i = 0; i < MaxTaps; i++) begin
      weight_reg[i] = 16'sd256;
      history[i] = '0;
    end
    held_count = 0;
  endtask

  // Shifts in one sample and returns the weighted average that follows from it.
  function automatic wma_result_t average_of(input logic signed [15:0] s);
    wma_result_t r;
    int unsigned eff;
    int unsigned used;
    longint signed wsum;
    longint signed tsum;
    longint signed avg;
    eff = (window_reg == 0) ? 1 : (window_reg > MaxTaps ? MaxTaps : window_reg);
    for (int i = MaxTaps - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = s;
    held_count = (held_count + 1 > eff) ? eff : held_count + 1;
    used = held_count;
    wsum = 0;
    tsum = 0;
    for (int i = 0; i < used; i++) begin
      wsum += longint'(history[i]) * longint'(weight_reg[i]);
      tsum += longint'(weight_reg[i]);
    end
    r.zero_weight_sum = (tsum == 0);
    // The divide truncates toward zero; a zero weight sum uses a floor shift.
    avg = (tsum != 0) ? wsum / tsum : (wsum >>> 8);
    r.saturated = 1'b0;
    if (avg > 32767) begin
      avg = 32767;
      r.saturated = 1'b1;
    end
    if (avg < -32768) begin
      avg = -32768;
      r.saturated = 1'b1;
    end
    r.average = avg[15:0];
    r.samples_used = used[2:0];
    return r;
  endfunction

  // Writes one register in the block and in the predictor. The caller makes
  // sure the block is idle.
  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegWindow) window_reg = val[2:0];
    else if (idx <= RegWeightLast) weight_reg[idx - 1] = val;
  endtask

  // Sends one request. The expected result is queued at the accepting edge,
  // so the store order always matches the order in which the block accepts.
  // Valid stays high after acceptance until a gap or a drain lowers it.
  task automatic send_sample(input logic signed [15:0] s, input bit gaps);
    int unsigned gap;
    gap = gaps ? $urandom_range(4, 0) : 0;
    if (gap != 0) begin
      @(negedge clk_i);
      sample_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    sample_valid_i <= 1'b1;
    sample_i <= s;
    do @(posedge clk_i); while (sample_stall_o);
    pending_results.push_back(average_of(s));
  endtask

  // Blocks until every queued result has come out, then lets the back end
  // settle before a register write is made.
  task automatic drain();
    @(negedge clk_i);
    sample_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // Receiver: draws at random for every result how long it stalls. The
  // hold_off flag keeps the stall high so that the front end queue fills and
  // the block stalls input.
  bit rx_random = 1'b1;
  int unsigned rx_wait = 0;
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        result_stall_i <= 1'b1;
      end else if (result_valid_o && rx_wait != 0) begin
        result_stall_i <= 1'b1;
        rx_wait--;
      end else begin
        result_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (result_valid_o && !result_stall_i)
      rx_wait = rx_random ? $urandom_range(4, 0) : 0;
  end

  // Checker: compares each accepted result with the oldest expected result.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o && !result_stall_i) begin
      wma_result_t exp_r;
      if (pending_results.size() == 0) begin
        $error("result with no expected result waiting: average %0d", average_o);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        results_seen++;
        if (exp_r.zero_weight_sum) zero_sum_seen++;
        if (exp_r.saturated) sat_seen++;
        if (average_o !== exp_r.average) begin
          $error("average: expected %0d, got %0d", exp_r.average, average_o);
          errors++;
        end
        if (saturated_o !== exp_r.saturated) begin
          $error("saturated: expected %0b, got %0b", exp_r.saturated, saturated_o);
          errors++;
        end
        if (zero_weight_sum_o !== exp_r.zero_weight_sum) begin
          $error("zero_weight_sum: expected %0b, got %0b",
                 exp_r.zero_weight_sum, zero_weight_sum_o);
          errors++;
        end
        if (samples_used_o !== exp_r.samples_used) begin
          $error("samples_used: expected %0d, got %0d", exp_r.samples_used, samples_used_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: ends the run if the stimulus never completes.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[weighted_moving_average_top] ERROR");
      $finish;
    end
  end

  // Random weight: Q8.8 values, mostly from the full range, sometimes extremes or moderate ones.
  function automatic logic [15:0] pick_weight();
    case ($urandom_range(5, 0))
      0: pick_weight = 16'h8000;
      1: pick_weight = 16'h7fff;
      2: pick_weight = 16'(int'($urandom_range(1024, 0)) - 512);
      default: pick_weight = 16'($urandom);
    endcase
  endfunction

  // Random sample: the extremes show up often to exercise saturation.
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(7, 0))
      0: pick_sample = 16'sh7fff;
      1: pick_sample = 16'sh8000;
      2: pick_sample = 16'(int'($urandom_range(64, 0)) - 32);
      default: pick_sample = 16'($urandom);
    endcase
  endfunction

  wma_row_t directed [$];
  logic [15:0] wsum_cancel;

  initial begin
    reset_model();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // After reset the weights are unity, the window is six and the history is
    // empty. The first results can be read off at a glance, so they are typed in.
    directed.push_back('{16'sd600, 1'b1, '{16'sd600, 1'b0, 1'b0, 3'd1}});
    directed.push_back('{16'sd0, 1'b1, '{16'sd300, 1'b0, 1'b0, 3'd2}});
    directed.push_back('{16'sh7fff, 1'b0, '0});
    directed.push_back('{16'sh8000, 1'b0, '0});
    directed.push_back('{16'sh7fff, 1'b0, '0});
    directed.push_back('{16'sh7fff, 1'b0, '0});
    directed.push_back('{-16'sd1, 1'b0, '0});
    directed.push_back('{16'sh8000, 1'b0, '0});
    foreach (directed[i]) begin
      wma_result_t want;
      send_sample(directed[i].sample, 1'b0);
      want = pending_results[$];
      if (directed[i].has_expect && want !== directed[i].want) begin
        $error("table row %0d: expected %0d, predictor has %0d",
               i, directed[i].want.average, want.average);
        errors++;
      end
    end
    drain();

    // A window of zero is treated as one.
    write_reg(RegWindow, 16'd0);
    send_sample(16'sd1234, 1'b0);
    send_sample(-16'sd77, 1'b0);
    drain();
    // A window above the tap count is treated as the tap count.
    write_reg(RegWindow, 16'd7);
    send_sample(16'sd5, 1'b0);
    drain();
    // The weight sum is zero: the raw sum is shifted, and floors toward minus
    // infinity. Large weights also push the shifted sum into saturation.
    write_reg(RegWindow, 16'd2);
    write_reg(3'd1, 16'h0100);
    write_reg(3'd2, 16'hff00);
    send_sample(-16'sd3, 1'b0);
    send_sample(16'sd2, 1'b0);
    drain();
    write_reg(3'd1, 16'h7fff);
    write_reg(3'd2, 16'h8001);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    drain();
    // Extreme weights of opposite sign, summing to minus one, saturate.
    write_reg(3'd1, 16'h8000);
    write_reg(3'd2, 16'h7fff);
    send_sample(16'sh7fff, 1'b0);
    drain();
    // An index above six changes nothing.
    write_reg(3'd7, 16'h1234);
    // Shrink the window, then grow it: the history refills one at a time.
    write_reg(RegWindow, 16'd1);
    send_sample(16'sd10, 1'b0);
    drain();
    write_reg(RegWindow, 16'd6);
    for (int i = 0; i < 3; i++) send_sample(pick_sample(), 1'b0);
    drain();

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < 34; ph++) begin
      // Windows cycle through every length, the extremes among them.
      write_reg(RegWindow, 16'(ph % 8));
      for (int w = 1; w <= MaxTaps; w++) write_reg(IdxW'(w), pick_weight());
      // Every third phase forces the weights of the window to cancel.
      if (ph % 3 == 2) begin
        wsum_cancel = '0;
        for (int w = 0; w < MaxTaps - 1; w++) wsum_cancel += weight_reg[w];
        write_reg(IdxW'(MaxTaps), -wsum_cancel);
        write_reg(RegWindow, 16'd6);
      end
      if (ph == 10) begin
        // Long hold-off at the receiver while the sender keeps offering, so the
        // block fills and stalls its input.
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(posedge clk_i);
            hold_off = 1'b0;
          end
          for (int i = 0; i < 50; i++) send_sample(pick_sample(), 1'b0);
        join
      end else begin
        // Odd phases offer back to back with a steady receiver.
        rx_random = (ph % 2 == 0);
        for (int i = 0; i < 48; i++) send_sample(pick_sample(), ph % 2 == 0);
      end
      // The sender pauses here until every expected result has come.
      drain();
    end
    rx_random = 1'b1;

    drain();
    $display("Covered %0d results, %0d with a zero weight sum, %0d saturated,",
             results_seen, zero_sum_seen, sat_seen);
    $display("over every window length, extreme weights and long receiver stalls.");
    if (errors == 0) begin
      $display("[weighted_moving_average_top] OK");
    end else begin
      $display("[weighted_moving_average_top] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
+incdir+sv
sv/wma_pkg.sv
sv/wma_front.sv
sv/wma_back.sv
sv/weighted_moving_average_top.sv
verif/weighted_moving_average_top_tb.sv
